// File: sv/pic_pkg.sv
// Shared types, codes and priority helpers for the interrupt controller.
package pic_pkg;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_READ  = 2'd1,
    FN_WRITE = 2'd2,
    FN_ACK   = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic        addr;
    logic [7:0]  wdata;
    logic [7:0]  irq_lines;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        int_out;
    logic        spurious;
  } out_item_t;

  // Init sequence position
  localparam logic [1:0] STEP_READY = 2'd0;
  localparam logic [1:0] STEP_ICW2  = 2'd1;
  localparam logic [1:0] STEP_ICW3  = 2'd2;
  localparam logic [1:0] STEP_ICW4  = 2'd3;

  // Command byte bit positions
  localparam int unsigned CMD_ICW1_BIT  = 4;
  localparam int unsigned CMD_OCW3_BIT  = 3;
  localparam int unsigned CMD_EOI_BIT   = 5;
  localparam int unsigned CMD_SL_BIT    = 6;
  localparam int unsigned CMD_POLL_BIT  = 2;
  localparam int unsigned CMD_RR_BIT    = 1;
  localparam int unsigned CMD_RIS_BIT   = 0;
  localparam int unsigned ICW1_LTIM_BIT = 3;
  localparam int unsigned ICW1_SNGL_BIT = 1;
  localparam int unsigned ICW1_IC4_BIT  = 0;
  localparam int unsigned ICW4_AEOI_BIT = 1;

  localparam logic [7:0] MASK_RESET = 8'hFF;
  localparam logic [7:0] POLL_FLAG  = 8'h80;
  localparam logic [7:0] POLL_NONE  = 8'h07;
  localparam logic [2:0] LEVEL_SPUR = 3'd7;
  localparam logic [3:0] NO_LEVEL   = 4'd8;

  // Level of the eligible request; bit 3 set when there is none.
  function automatic logic [3:0] eligible_level(input logic [7:0] irr,
                                                input logic [7:0] isr,
                                                input logic [7:0] imr);
    logic [7:0] pend;
    logic [7:0] upto;
    logic [3:0] lvl;
    pend = irr & ~imr;
    lvl  = NO_LEVEL;
    for (int i = 7; i >= 0; i--) begin
      if (pend[i]) lvl = 4'(i);
    end
    // Block on any in-service level at or above this one
    upto = (8'd2 << lvl[2:0]) - 8'd1;
    if (!lvl[3] && ((isr & upto) != 8'd0)) lvl = NO_LEVEL;
    return lvl;
  endfunction

  // One-hot of the lowest set bit, zero when none.
  function automatic logic [7:0] lowest_one(input logic [7:0] v);
    return v & (~v + 8'd1);
  endfunction

endpackage

// File: sv/pic_if.sv
// Valid/ready channel interfaces for controller items and results.
interface pic_in_if;
  import pic_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pic_out_if;
  import pic_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/programmable_interrupt_controller_top.sv
// Top level: input register, controller core and result register.
//
//   channel  dir   modport  payload
//   in_i     in    sink     func, addr, wdata, irq_lines
//   out_o    out   source   rdata, int_out, spurious
//
// One item per cycle sustained while results are taken; an accepted item goes
// to the input register, then its result to the result register (out_o.data).
// The core state advances when the input register hands its item to the
// result register, so each item sees the state the previous one left.
// rst_ni resets the controller state (mask set to all ones) and clears both valid flags at once.
// A stalled result holds; the input register then holds one more item.
module programmable_interrupt_controller_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  pic_in_if.sink   in_i,
  pic_out_if.source out_o
);
  import pic_pkg::*;

  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q;
  out_item_t res;
  logic      out_vld_q, out_vld_d;
  logic      adv;
  logic      in_take;

  assign adv       = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | adv;
  assign in_take   = in_i.valid & in_i.ready;
  assign in_vld_d  = in_take | (in_vld_q & ~adv);
  assign out_vld_d = adv | (out_vld_q & ~out_o.ready);

  pic_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q  <= in_i.data;
    if (adv)     out_q <= res;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

// File: sv/pic_core.sv
// Controller state registers and the per-item update and result logic.
module pic_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  pic_pkg::in_item_t  item_i,
  output pic_pkg::out_item_t res_o
);
  import pic_pkg::*;

  logic [7:0] irr_q, irr_d, isr_q, isr_d, imr_q, imr_d, last_q, last_d;
  logic [4:0] vec_q, vec_d;
  logic [1:0] step_q, step_d;
  logic       icw4_q, icw4_d, single_q, single_d, aeoi_q, aeoi_d;
  logic       level_q, level_d, sel_q, sel_d, poll_q, poll_d;

  logic [7:0] irr_s;
  logic [3:0] elig;
  logic [3:0] elig_post;
  logic [7:0] take_bit;
  logic [7:0] wd;
  logic       do_take;

  always_comb begin
    wd    = item_i.wdata;
    irr_s = level_q ? item_i.irq_lines : (irr_q | (item_i.irq_lines & ~last_q));
    elig  = eligible_level(irr_s, isr_q, imr_q);
    take_bit = 8'd1 << elig[2:0];

    irr_d    = irr_s;
    isr_d    = isr_q;
    imr_d    = imr_q;
    last_d   = item_i.irq_lines;
    vec_d    = vec_q;
    step_d   = step_q;
    icw4_d   = icw4_q;
    single_d = single_q;
    aeoi_d   = aeoi_q;
    level_d  = level_q;
    sel_d    = sel_q;
    poll_d   = poll_q;
    do_take  = 1'b0;

    res_o.rdata    = 8'd0;
    res_o.spurious = 1'b0;

    case (item_i.func)
      FN_READ: begin
        if (poll_q) begin
          poll_d = 1'b0;
          if (!elig[3]) begin
            res_o.rdata = POLL_FLAG | {5'd0, elig[2:0]};
            do_take     = 1'b1;
          end else begin
            res_o.rdata    = POLL_NONE;
            res_o.spurious = 1'b1;
          end
        end else if (item_i.addr) begin
          res_o.rdata = imr_q;
        end else begin
          res_o.rdata = sel_q ? isr_q : irr_s;
        end
      end
      FN_WRITE: begin
        if (item_i.addr) begin
          case (step_q)
            STEP_ICW2: begin
              vec_d = wd[7:3];
              if (single_q) step_d = icw4_q ? STEP_ICW4 : STEP_READY;
              else          step_d = STEP_ICW3;
            end
            STEP_ICW3: step_d = icw4_q ? STEP_ICW4 : STEP_READY;
            STEP_ICW4: begin
              aeoi_d = wd[ICW4_AEOI_BIT];
              step_d = STEP_READY;
            end
            default: imr_d = wd;
          endcase
        end else if (wd[CMD_ICW1_BIT]) begin
          // Restart init; current lines stay as the edge reference
          irr_d    = 8'd0;
          isr_d    = 8'd0;
          imr_d    = 8'd0;
          poll_d   = 1'b0;
          sel_d    = 1'b0;
          level_d  = wd[ICW1_LTIM_BIT];
          single_d = wd[ICW1_SNGL_BIT];
          icw4_d   = wd[ICW1_IC4_BIT];
          if (!wd[ICW1_IC4_BIT]) aeoi_d = 1'b0;
          step_d   = STEP_ICW2;
        end else if (wd[CMD_OCW3_BIT]) begin
          if (wd[CMD_POLL_BIT]) poll_d = 1'b1;
          if (wd[CMD_RR_BIT])   sel_d  = wd[CMD_RIS_BIT];
        end else if (wd[CMD_EOI_BIT]) begin
          if (wd[CMD_SL_BIT]) isr_d = isr_q & ~(8'd1 << wd[2:0]);
          else                isr_d = isr_q & ~lowest_one(isr_q);
        end
      end
      FN_ACK: begin
        if (!elig[3]) begin
          res_o.rdata = {vec_q, elig[2:0]};
          do_take     = 1'b1;
        end else begin
          res_o.rdata    = {vec_q, LEVEL_SPUR};
          res_o.spurious = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_take) begin
      irr_d = irr_s & ~take_bit;
      if (!aeoi_q) isr_d = isr_q | take_bit;
    end

    elig_post     = eligible_level(irr_d, isr_d, imr_d);
    res_o.int_out = ~elig_post[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irr_q    <= 8'd0;
      isr_q    <= 8'd0;
      imr_q    <= MASK_RESET;
      last_q   <= 8'd0;
      vec_q    <= 5'd0;
      step_q   <= STEP_READY;
      icw4_q   <= 1'b0;
      single_q <= 1'b0;
      aeoi_q   <= 1'b0;
      level_q  <= 1'b0;
      sel_q    <= 1'b0;
      poll_q   <= 1'b0;
    end else if (en_i) begin
      irr_q    <= irr_d;
      isr_q    <= isr_d;
      imr_q    <= imr_d;
      last_q   <= last_d;
      vec_q    <= vec_d;
      step_q   <= step_d;
      icw4_q   <= icw4_d;
      single_q <= single_d;
      aeoi_q   <= aeoi_d;
      level_q  <= level_d;
      sel_q    <= sel_d;
      poll_q   <= poll_d;
    end
  end

endmodule
